[hw/rtl/grv_pkg.sv]
package grv_pkg;

  localparam int MAX_BODIES_DEF = 4;

  // Divider and root widths
  localparam int DIV_W = 48;
  localparam int DIV_CW = 6;
  localparam int RAD_W = 64;
  localparam int ROOT_W = 32;

  localparam logic [47:0] D2_MAX = 48'hFFFF_FFFF_FFFF;

  // Input actions
  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_ADV = 2'd2;

  // End reasons
  localparam logic [1:0] RSN_RUN = 2'd0;
  localparam logic [1:0] RSN_CRASH = 2'd1;
  localparam logic [1:0] RSN_ESC = 2'd2;
  localparam logic [1:0] RSN_LIMIT = 2'd3;

  // Register indexes
  localparam logic [2:0] CFG_BASE_STEP = 3'd0;
  localparam logic [2:0] CFG_GAIN = 3'd1;
  localparam logic [2:0] CFG_NEAR = 3'd2;
  localparam logic [2:0] CFG_FAR = 3'd3;
  localparam logic [2:0] CFG_BOUND = 3'd4;
  localparam logic [2:0] CFG_MAX_STEPS = 3'd5;
  localparam logic [2:0] CFG_INTERVAL = 3'd6;
  localparam logic [2:0] CFG_BODY_COUNT = 3'd7;

  // Register reset values
  localparam logic [15:0] RST_BASE_STEP = 16'd655;
  localparam logic [7:0] RST_GAIN = 8'd5;
  localparam logic [31:0] RST_NEAR = 32'd32768000;
  localparam logic [31:0] RST_FAR = 32'd131072000;
  localparam logic [30:0] RST_BOUND = 31'd13107200;
  localparam logic [15:0] RST_MAX_STEPS = 16'd2000;
  localparam logic [7:0] RST_INTERVAL = 8'd10;
  localparam logic [2:0] RST_BODY_COUNT = 3'd3;

  typedef struct packed {
    logic start;
    logic [DIV_CW-1:0] iters;
  } div_req_t;

endpackage

[hw/rtl/grv_mul.sv]
module grv_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p_r
);
  import grv_pkg::*;

  always_ff @(posedge clk) begin
    p_r <= 64'(a) * 64'(b);
  end

endmodule

[hw/rtl/grv_div.sv]
module grv_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  grv_pkg::div_req_t     req,
  input  logic [grv_pkg::DIV_W-1:0] rem0,
  input  logic [grv_pkg::DIV_W-1:0] num,
  input  logic [grv_pkg::DIV_W-1:0] den,
  output logic                  done_r,
  output logic [grv_pkg::DIV_W-1:0] quo_r,
  output logic [grv_pkg::DIV_W-1:0] rem_r
);
  import grv_pkg::*;

  logic [DIV_W-1:0]  num_r;
  logic [DIV_W-1:0]  den_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              run_r;
  logic [DIV_W:0]    rem_t;
  logic              fit;

  // One quotient bit a cycle, numerator bits shifted in from the top
  assign rem_t = {rem_r, num_r[DIV_W-1]};
  assign fit = rem_t >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= req.iters - 1'b1;
        rem_r <= rem0;
        num_r <= num;
        den_r <= den;
        quo_r <= '0;
      end else if (run_r) begin
        rem_r <= fit ? DIV_W'(rem_t - {1'b0, den_r}) : rem_t[DIV_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], fit};
        num_r <= {num_r[DIV_W-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/grv_sqrt.sv]
module grv_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [grv_pkg::RAD_W-1:0]  rad,
  output logic                       done_r,
  output logic [grv_pkg::ROOT_W-1:0] root_r
);
  import grv_pkg::*;

  logic [RAD_W-1:0]  rad_r;
  logic [ROOT_W+2:0] rem_r;
  logic [4:0]        cnt_r;
  logic              run_r;
  logic [ROOT_W+2:0] rem_t;
  logic [ROOT_W+2:0] trial;
  logic              fit;

  // Two radicand bits a cycle, one root bit out
  assign rem_t = {rem_r[ROOT_W:0], rad_r[RAD_W-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign fit = rem_t >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 5'd31;
        rad_r <= rad;
        rem_r <= '0;
        root_r <= '0;
      end else if (run_r) begin
        rem_r <= fit ? (rem_t - trial) : rem_t;
        root_r <= {root_r[ROOT_W-2:0], fit};
        rad_r <= {rad_r[RAD_W-3:0], 2'b00};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/gravity_ray_integrator.sv]
// Ray marcher in signed Q16.16. A load word writes one body entry; a start
// word places the ray and returns its start point. An advance word runs one
// integration step on one shared 32x32 multiplier, a one-bit-a-cycle divider
// and a one-bit-a-cycle root unit, all under one sequencer: setup, then for
// each body in use the distance, the root unit, two divides and the terms (a
// body whose pull saturates skips the second divide), then the update, plus
// a sample check divide on a running step. A crash ends the body walk at
// once. The input stalls while a word is in work; a finished point waits in
// the output register and does not hold up the next word.
module gravity_ray_integrator #(
  parameter int MAX_BODIES = grv_pkg::MAX_BODIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [1:0]         in_body_index,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_vel_z,
  input  logic [30:0]        in_mass,
  input  logic [30:0]        in_radius,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               out_keep_point,
  output logic               out_ended,
  output logic [1:0]         out_end_reason,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import grv_pkg::*;

  localparam int IW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int CW = $clog2(MAX_BODIES + 1);
  localparam int AW = 57 + CW;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_SQX, S_SQY, S_SQZ, S_SQR, S_CHK, S_SQRT,
    S_DIVQ, S_DIVM, S_TERM, S_STEP, S_UPD, S_MOD, S_OUT
  } state_t;

  state_t state_r;
  logic [3:0] k_r;
  logic [CW-1:0] bi_r;

  logic [15:0] base_step_r;
  logic [7:0]  gain_r;
  logic [31:0] near_r;
  logic [31:0] far_r;
  logic [30:0] bound_r;
  logic [15:0] max_steps_r;
  logic [7:0]  interval_r;
  logic [2:0]  body_count_r;

  logic signed [31:0] bpx_r [MAX_BODIES];
  logic signed [31:0] bpy_r [MAX_BODIES];
  logic signed [31:0] bpz_r [MAX_BODIES];
  logic [30:0] bmass_r [MAX_BODIES];
  logic [30:0] brad_r [MAX_BODIES];

  logic signed [31:0] pos_r [3];
  logic signed [31:0] vel_r [3];
  logic [15:0] step_r;
  logic active_r;

  logic signed [32:0] d_r [3];
  logic [49:0] d2_r;
  logic [47:0] dmin_r;
  logic [31:0] dist_r;
  logic [30:0] mag_r;
  logic [46:0] t_r [3];
  logic [31:0] lo_r;
  logic signed [AW-1:0] acc_r [3];
  logic signed [31:0] a_r [3];
  logic [18:0] dt_r;

  logic res_keep_r;
  logic res_ended_r;
  logic [1:0] res_reason_r;

  logic out_valid_r;
  logic signed [31:0] out_x_r, out_y_r, out_z_r;
  logic out_keep_r, out_ended_r;
  logic [1:0] out_reason_r;

  logic sq_start_r;
  div_req_t div_req_r;
  logic [DIV_W-1:0] div_rem0_r, div_num_r, div_den_r;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic sq_done;
  logic [31:0] sq_root;
  logic div_done;
  logic [DIV_W-1:0] div_quo, div_rem;

  logic [31:0] u_w [3];
  logic [IW-1:0] bidx;
  logic [CW-1:0] n_use;
  logic last_body;
  logic [47:0] d2s;
  logic [47:0] r2;
  logic [IW-1:0] widx;
  logic accept;
  logic escape;
  logic [7:0] ival;

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    abs32 = v[31] ? 32'(-v) : v;
  endfunction

  // v +/- m, clamped to the Q16.16 range
  function automatic logic signed [31:0] upd32(input logic signed [31:0] v,
                                               input logic neg,
                                               input logic [34:0] m);
    logic signed [36:0] s;
    s = 37'(v) + (neg ? -$signed({2'b00, m}) : $signed({2'b00, m}));
    if (s > 37'sd2147483647) upd32 = 32'sh7FFF_FFFF;
    else if (s < -37'sd2147483648) upd32 = 32'sh8000_0000;
    else upd32 = s[31:0];
  endfunction

  function automatic logic signed [AW-1:0] add_term(input logic signed [AW-1:0] acc,
                                                   input logic neg,
                                                   input logic [31:0] lo,
                                                   input logic [31:0] hi);
    logic [55:0] m;
    m = {hi[31:0], 24'b0} + 56'(lo);
    add_term = neg ? acc - $signed(AW'(m)) : acc + $signed(AW'(m));
  endfunction

  function automatic logic signed [31:0] sat_acc(input logic signed [AW-1:0] v);
    if (v > $signed(AW'(32'h7FFF_FFFF))) sat_acc = 32'sh7FFF_FFFF;
    else if (v < $signed({{(AW-31){1'b1}}, 31'b0})) sat_acc = 32'sh8000_0000;
    else sat_acc = v[31:0];
  endfunction

  grv_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  grv_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sq_start_r),
    .rad    ({d2_r[47:0], 16'b0}),
    .done_r (sq_done),
    .root_r (sq_root)
  );

  grv_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (div_req_r),
    .rem0   (div_rem0_r),
    .num    (div_num_r),
    .den    (div_den_r),
    .done_r (div_done),
    .quo_r  (div_quo),
    .rem_r  (div_rem)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign bidx = bi_r[IW-1:0];
  assign n_use = (32'(body_count_r) < MAX_BODIES) ? CW'(body_count_r) : CW'(MAX_BODIES);
  assign last_body = ((CW+1)'(bi_r) + 1'b1) >= (CW+1)'(n_use);
  assign d2s = (d2_r > 50'(D2_MAX)) ? D2_MAX : d2_r[47:0];
  assign r2 = mul_p[63:16];
  assign widx = IW'(in_body_index);
  assign ival = (interval_r == '0) ? 8'd1 : interval_r;
  assign escape = (abs32(pos_r[0]) > {1'b0, bound_r}) ||
                  (abs32(pos_r[1]) > {1'b0, bound_r}) ||
                  (abs32(pos_r[2]) > {1'b0, bound_r});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_w[i] = d_r[i][32] ? 32'(-d_r[i]) : d_r[i][31:0];
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SQX: begin mul_a = u_w[0]; mul_b = u_w[0]; end
      S_SQY: begin mul_a = u_w[1]; mul_b = u_w[1]; end
      S_SQZ: begin mul_a = u_w[2]; mul_b = u_w[2]; end
      S_SQR: begin mul_a = {1'b0, brad_r[bidx]}; mul_b = {1'b0, brad_r[bidx]}; end
      S_TERM: begin
        case (k_r)
          4'd0: begin mul_a = u_w[0]; mul_b = {1'b0, mag_r}; end
          4'd1: begin mul_a = u_w[1]; mul_b = {1'b0, mag_r}; end
          4'd2: begin mul_a = u_w[2]; mul_b = {1'b0, mag_r}; end
          4'd3: begin mul_a = {8'b0, t_r[0][23:0]}; mul_b = {24'b0, gain_r}; end
          4'd4: begin mul_a = {9'b0, t_r[0][46:24]}; mul_b = {24'b0, gain_r}; end
          4'd5: begin mul_a = {8'b0, t_r[1][23:0]}; mul_b = {24'b0, gain_r}; end
          4'd6: begin mul_a = {9'b0, t_r[1][46:24]}; mul_b = {24'b0, gain_r}; end
          4'd7: begin mul_a = {8'b0, t_r[2][23:0]}; mul_b = {24'b0, gain_r}; end
          4'd8: begin mul_a = {9'b0, t_r[2][46:24]}; mul_b = {24'b0, gain_r}; end
          default: ;
        endcase
      end
      S_UPD: begin
        case (k_r)
          4'd0: begin mul_a = abs32(a_r[0]); mul_b = {13'b0, dt_r}; end
          4'd1: begin mul_a = abs32(a_r[1]); mul_b = {13'b0, dt_r}; end
          4'd2: begin mul_a = abs32(a_r[2]); mul_b = {13'b0, dt_r}; end
          4'd3: begin mul_a = abs32(vel_r[0]); mul_b = {13'b0, dt_r}; end
          4'd4: begin mul_a = abs32(vel_r[1]); mul_b = {13'b0, dt_r}; end
          4'd5: begin mul_a = abs32(vel_r[2]); mul_b = {13'b0, dt_r}; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r <= '0;
      bi_r <= '0;
      active_r <= 1'b0;
      step_r <= '0;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
      sq_start_r <= 1'b0;
      div_req_r <= '0;
      base_step_r <= RST_BASE_STEP;
      gain_r <= RST_GAIN;
      near_r <= RST_NEAR;
      far_r <= RST_FAR;
      bound_r <= RST_BOUND;
      max_steps_r <= RST_MAX_STEPS;
      interval_r <= RST_INTERVAL;
      body_count_r <= RST_BODY_COUNT;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_OUT) out_valid_r <= 1'b0;

      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_BASE_STEP:  base_step_r <= cfg_data[15:0];
          CFG_GAIN:       gain_r <= cfg_data[7:0];
          CFG_NEAR:       near_r <= cfg_data;
          CFG_FAR:        far_r <= cfg_data;
          CFG_BOUND:      bound_r <= cfg_data[30:0];
          CFG_MAX_STEPS:  max_steps_r <= cfg_data[15:0];
          CFG_INTERVAL:   interval_r <= cfg_data[7:0];
          CFG_BODY_COUNT: body_count_r <= cfg_data[2:0];
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_action)
              ACT_LOAD: begin
                if (32'(in_body_index) < MAX_BODIES) begin
                  bpx_r[widx] <= in_pos_x;
                  bpy_r[widx] <= in_pos_y;
                  bpz_r[widx] <= in_pos_z;
                  bmass_r[widx] <= in_mass;
                  brad_r[widx] <= in_radius;
                end
              end
              ACT_START: begin
                pos_r[0] <= in_pos_x;
                pos_r[1] <= in_pos_y;
                pos_r[2] <= in_pos_z;
                vel_r[0] <= in_vel_x;
                vel_r[1] <= in_vel_y;
                vel_r[2] <= in_vel_z;
                step_r <= '0;
                active_r <= 1'b1;
                res_keep_r <= 1'b1;
                res_ended_r <= 1'b0;
                res_reason_r <= RSN_RUN;
                state_r <= S_OUT;
              end
              ACT_ADV: begin
                if (active_r) begin
                  bi_r <= '0;
                  dmin_r <= D2_MAX;
                  for (int i = 0; i < 3; i++) acc_r[i] <= '0;
                  state_r <= (n_use == '0) ? S_STEP : S_DIFF;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIFF: begin
          d_r[0] <= 33'(bpx_r[bidx]) - 33'(pos_r[0]);
          d_r[1] <= 33'(bpy_r[bidx]) - 33'(pos_r[1]);
          d_r[2] <= 33'(bpz_r[bidx]) - 33'(pos_r[2]);
          state_r <= S_SQX;
        end
        S_SQX: state_r <= S_SQY;
        S_SQY: begin
          d2_r <= 50'(mul_p[63:16]);
          state_r <= S_SQZ;
        end
        S_SQZ: begin
          d2_r <= d2_r + 50'(mul_p[63:16]);
          state_r <= S_SQR;
        end
        S_SQR: begin
          d2_r <= d2_r + 50'(mul_p[63:16]);
          state_r <= S_CHK;
        end
        S_CHK: begin
          d2_r <= 50'(d2s);
          if (d2s < r2) begin
            // inside the body: stop where the ray stands
            active_r <= 1'b0;
            res_keep_r <= 1'b1;
            res_ended_r <= 1'b1;
            res_reason_r <= RSN_CRASH;
            state_r <= S_OUT;
          end else begin
            if (d2s < dmin_r) dmin_r <= d2s;
            if (d2s == '0) begin
              bi_r <= bi_r + 1'b1;
              state_r <= last_body ? S_STEP : S_DIFF;
            end else begin
              sq_start_r <= 1'b1;
              state_r <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          sq_start_r <= 1'b0;
          if (sq_done) begin
            dist_r <= sq_root;
            div_req_r.start <= 1'b1;
            div_req_r.iters <= DIV_CW'(47);
            div_rem0_r <= '0;
            div_num_r <= {bmass_r[bidx], 17'b0};
            div_den_r <= d2_r[47:0];
            state_r <= S_DIVQ;
          end
        end
        S_DIVQ: begin
          if (div_done) begin
            if (div_quo[46:15] >= dist_r) begin
              mag_r <= 31'h7FFF_FFFF;
              k_r <= '0;
              state_r <= S_TERM;
            end else begin
              div_req_r.start <= 1'b1;
              div_req_r.iters <= DIV_CW'(31);
              div_rem0_r <= {16'b0, div_quo[46:15]};
              div_num_r <= {div_quo[14:0], 33'b0};
              div_den_r <= {16'b0, dist_r};
              state_r <= S_DIVM;
            end
          end else begin
            div_req_r.start <= 1'b0;
          end
        end
        S_DIVM: begin
          if (div_done) begin
            mag_r <= div_quo[30:0];
            k_r <= '0;
            state_r <= S_TERM;
          end else begin
            div_req_r.start <= 1'b0;
          end
        end
        S_TERM: begin
          k_r <= k_r + 1'b1;
          case (k_r)
            4'd1: t_r[0] <= mul_p[62:16];
            4'd2: t_r[1] <= mul_p[62:16];
            4'd3: t_r[2] <= mul_p[62:16];
            4'd4: lo_r <= mul_p[31:0];
            4'd5: acc_r[0] <= add_term(acc_r[0], d_r[0][32], lo_r, mul_p[31:0]);
            4'd6: lo_r <= mul_p[31:0];
            4'd7: acc_r[1] <= add_term(acc_r[1], d_r[1][32], lo_r, mul_p[31:0]);
            4'd8: lo_r <= mul_p[31:0];
            4'd9: begin
              acc_r[2] <= add_term(acc_r[2], d_r[2][32], lo_r, mul_p[31:0]);
              bi_r <= bi_r + 1'b1;
              state_r <= last_body ? S_STEP : S_DIFF;
            end
            default: ;
          endcase
        end
        S_STEP: begin
          dt_r <= {3'b0, base_step_r} << {(dmin_r > 48'(far_r)), (dmin_r > 48'(near_r))};
          for (int i = 0; i < 3; i++) a_r[i] <= sat_acc(acc_r[i]);
          k_r <= '0;
          state_r <= S_UPD;
        end
        S_UPD: begin
          k_r <= k_r + 1'b1;
          case (k_r)
            4'd1: vel_r[0] <= upd32(vel_r[0], a_r[0][31], mul_p[50:16]);
            4'd2: vel_r[1] <= upd32(vel_r[1], a_r[1][31], mul_p[50:16]);
            4'd3: vel_r[2] <= upd32(vel_r[2], a_r[2][31], mul_p[50:16]);
            4'd4: pos_r[0] <= upd32(pos_r[0], vel_r[0][31], mul_p[50:16]);
            4'd5: pos_r[1] <= upd32(pos_r[1], vel_r[1][31], mul_p[50:16]);
            4'd6: pos_r[2] <= upd32(pos_r[2], vel_r[2][31], mul_p[50:16]);
            4'd7: begin
              if (escape) begin
                active_r <= 1'b0;
                res_keep_r <= 1'b1;
                res_ended_r <= 1'b1;
                res_reason_r <= RSN_ESC;
                state_r <= S_OUT;
              end else if ((17'(step_r) + 17'd1) >= 17'(max_steps_r)) begin
                active_r <= 1'b0;
                step_r <= step_r + 1'b1;
                res_keep_r <= 1'b1;
                res_ended_r <= 1'b1;
                res_reason_r <= RSN_LIMIT;
                state_r <= S_OUT;
              end else begin
                div_req_r.start <= 1'b1;
                div_req_r.iters <= DIV_CW'(16);
                div_rem0_r <= '0;
                div_num_r <= {step_r, 32'b0};
                div_den_r <= DIV_W'(ival);
                state_r <= S_MOD;
              end
            end
            default: ;
          endcase
        end
        S_MOD: begin
          if (div_done) begin
            res_keep_r <= (div_rem == '0);
            res_ended_r <= 1'b0;
            res_reason_r <= RSN_RUN;
            step_r <= step_r + 1'b1;
            state_r <= S_OUT;
          end else begin
            div_req_r.start <= 1'b0;
          end
        end
        S_OUT: begin
          // hold until the output register frees up
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_x_r <= pos_r[0];
            out_y_r <= pos_r[1];
            out_z_r <= pos_r[2];
            out_keep_r <= res_keep_r;
            out_ended_r <= res_ended_r;
            out_reason_r <= res_reason_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_x = out_x_r;
  assign out_y = out_y_r;
  assign out_z = out_z_r;
  assign out_keep_point = out_keep_r;
  assign out_ended = out_ended_r;
  assign out_end_reason = out_reason_r;

endmodule

[hw/rtl/grv_chk.sv]
module grv_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         in_action,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_x,
  input logic               out_keep_point,
  input logic               out_ended,
  input logic [1:0]         out_end_reason
);
  import grv_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_x))
    else $error("stalled result word changed");

  a_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ended == (out_end_reason != RSN_RUN)))
    else $error("end flag and end reason disagree");

  a_end_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ended |-> out_keep_point)
    else $error("final point not kept");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action == ACT_START |=> in_stall)
    else $error("start word did not occupy the block");

endmodule

bind gravity_ray_integrator grv_chk u_grv_chk (.*);
